@@ hw/rtl/tte_pkg.sv @@
`timescale 1ns / 1ps
package tte_pkg;

  localparam int MAX_TERMS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;

  localparam int ANGLE_W    = 19;
  localparam int ANGLE_FRAC = 16;
  localparam int MODE_W     = 3;
  localparam int VAL_W      = 32;
  localparam int TOL_W      = 16;
  localparam int DW         = 64;   // term, sum and divider width
  localparam int MUL_STEPS  = 4;    // 32x32 partial products per multiply

  localparam logic [MODE_W-1:0] MODE_SIN = 3'd0;
  localparam logic [MODE_W-1:0] MODE_COS = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SEC = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CSC = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TAN = 3'd4;
  localparam logic [MODE_W-1:0] MODE_COT = 3'd5;

  localparam logic REG_SINE_TOL = 1'b0;
  localparam logic REG_COS_TOL  = 1'b1;

  localparam logic [TOL_W-1:0] SINE_TOL_RST = 16'd66;
  localparam logic [TOL_W-1:0] COS_TOL_RST  = 16'd7;

  typedef struct packed {
    logic       load_in;
    logic       mul_clr;
    logic       mul_acc;
    logic [1:0] mul_idx;
    logic       mul_sel;    // 0: x*x, 1: term*x2
    logic       x2_load;
    logic       ser_init;
    logic       init_cos;
    logic       ser_cos;
    logic       ser_add;
    logic       ser_sub;
    logic       div_start;
    logic       div_quot;   // 0: term divide, 1: final quotient
    logic       div_step;
    logic       term_upd;
    logic       sin_store;
    logic       cos_store;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic t_below;
    logic mode_sine;
    logic mode_ratio;
    logic quot_dz;
  } dp_sts_t;

  // clamp to the signed 32 bit range, flag in the top bit
  function automatic logic [VAL_W:0] sat32(input logic signed [DW-1:0] v);
    logic [VAL_W:0] r;
    if (v > DW'(64'sd2147483647)) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -DW'(64'sd2147483648)) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[VAL_W-1:0]};
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/tte_datapath.sv @@
`timescale 1ns / 1ps
module tte_datapath import tte_pkg::*; #(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  dp_cmd_t                 cmd_i,
  output dp_sts_t                 sts_o,
  input  logic [ANGLE_W-1:0]      angle_i,
  input  logic [MODE_W-1:0]       mode_i,
  input  logic [TOL_W-1:0]        sine_tol_i,
  input  logic [TOL_W-1:0]        cos_tol_i,
  output logic signed [VAL_W-1:0] value_o,
  output logic                    saturated_o,
  output logic                    divide_by_zero_o
);

  localparam int NW  = $clog2(2 * MAX_TERMS + 4);
  localparam int SHL = (FRAC_BITS >= ANGLE_FRAC) ? FRAC_BITS - ANGLE_FRAC : 0;
  localparam int SHR = (FRAC_BITS >= ANGLE_FRAC) ? 0 : ANGLE_FRAC - FRAC_BITS;
  localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;

  logic [MODE_W-1:0]      mode_q;
  logic [DW-1:0]          x_q, x2_q, t_q;
  logic [NW-1:0]          n_q;
  logic signed [DW-1:0]   sum_q;
  logic [VAL_W-1:0]       s_q, c_q;
  logic                   sat_s_q, sat_c_q;
  logic [DW-1:0]          prod_q;
  logic [1:0]             pidx_q;
  logic [2*DW-1:0]        acc_q;
  logic [DW-1:0]          dvd_q, dvs_q, rem_q;
  logic [VAL_W-1:0]       value_q;
  logic                   sat_q, dz_q;

  // multiplier: one 32x32 partial product per cycle
  logic [DW-1:0]   a_op, b_op;
  logic [31:0]     pa, pb;
  logic [2*DW-1:0] psh;

  assign a_op = cmd_i.mul_sel ? t_q  : x_q;
  assign b_op = cmd_i.mul_sel ? x2_q : x_q;

  always_comb begin
    unique case (cmd_i.mul_idx)
      2'd0: begin pa = a_op[31:0];  pb = b_op[31:0];  end
      2'd1: begin pa = a_op[31:0];  pb = b_op[63:32]; end
      2'd2: begin pa = a_op[63:32]; pb = b_op[31:0];  end
      default: begin pa = a_op[63:32]; pb = b_op[63:32]; end
    endcase
  end

  always_comb begin
    unique case (pidx_q)
      2'd0:    psh = {{DW{1'b0}}, prod_q};
      2'd3:    psh = {prod_q, {DW{1'b0}}};
      default: psh = {{(DW/2){1'b0}}, prod_q, {(DW/2){1'b0}}};
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= DW'(pa) * DW'(pb);
    pidx_q <= cmd_i.mul_idx;
    if (cmd_i.mul_clr) begin
      acc_q <= '0;
    end else if (cmd_i.mul_acc) begin
      acc_q <= acc_q + psh;
    end
  end

  // input capture, x^2 and series registers
  logic [DW-1:0]   x_in;
  logic [NW-1:0]   np1, np2;
  logic [2*NW-1:0] nprod;
  logic [DW-1:0]   tol;

  assign x_in  = (DW'(angle_i) << SHL) >> SHR;
  assign np1   = n_q + NW'(1);
  assign np2   = n_q + NW'(2);
  assign nprod = np1 * np2;
  assign tol   = cmd_i.ser_cos ? DW'(cos_tol_i) : DW'(sine_tol_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q <= mode_i;
      x_q    <= x_in;
    end
    if (cmd_i.x2_load) begin
      x2_q <= acc_q[FRAC_BITS +: DW];
    end
    if (cmd_i.ser_init) begin
      t_q   <= cmd_i.init_cos ? ONE : x_q;
      n_q   <= cmd_i.init_cos ? NW'(0) : NW'(1);
      sum_q <= '0;
    end else begin
      if (cmd_i.ser_add) begin
        sum_q <= cmd_i.ser_sub ? sum_q - $signed(t_q) : sum_q + $signed(t_q);
      end
      if (cmd_i.term_upd) begin
        t_q <= dvd_q;
        n_q <= np2;
      end
    end
    if (cmd_i.sin_store) begin
      {sat_s_q, s_q} <= sat32(sum_q);
    end
    if (cmd_i.cos_store) begin
      {sat_c_q, c_q} <= sat32(sum_q);
    end
  end

  // quotient operands
  logic signed [VAL_W-1:0] qa, qb;
  logic [VAL_W-1:0]        ua, ub;
  logic                    q_dz, q_neg, q_base;

  always_comb begin
    unique case (mode_q)
      MODE_SEC: begin qa = VAL_W'(ONE); qb = c_q; q_base = sat_c_q; end
      MODE_CSC: begin qa = VAL_W'(ONE); qb = s_q; q_base = sat_s_q; end
      MODE_TAN: begin qa = s_q; qb = c_q; q_base = sat_s_q | sat_c_q; end
      MODE_COT: begin qa = c_q; qb = s_q; q_base = sat_s_q | sat_c_q; end
      default:  begin qa = s_q; qb = c_q; q_base = 1'b0; end
    endcase
  end

  assign ua    = qa[VAL_W-1] ? (~qa + 1'b1) : qa;
  assign ub    = qb[VAL_W-1] ? (~qb + 1'b1) : qb;
  assign q_dz  = (qb == '0);
  assign q_neg = qa[VAL_W-1] ^ qb[VAL_W-1];

  // restoring divider, one quotient bit per cycle
  logic [DW:0] rsh, rdif;

  assign rsh  = {rem_q, dvd_q[DW-1]};
  assign rdif = rsh - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      if (cmd_i.div_quot) begin
        dvd_q <= DW'(ua) << FRAC_BITS;
        dvs_q <= DW'(ub);
      end else begin
        dvd_q <= acc_q[FRAC_BITS +: DW];
        dvs_q <= DW'(nprod);
      end
    end else if (cmd_i.div_step) begin
      if (!rdif[DW]) begin
        rem_q <= rdif[DW-1:0];
        dvd_q <= {dvd_q[DW-2:0], 1'b1};
      end else begin
        rem_q <= rsh[DW-1:0];
        dvd_q <= {dvd_q[DW-2:0], 1'b0};
      end
    end
  end

  // result selection into the output register
  logic [VAL_W-1:0] r_val;
  logic             r_sat, r_dz;

  always_comb begin
    r_val = '0;
    r_sat = 1'b0;
    r_dz  = 1'b0;
    unique case (mode_q)
      MODE_SIN: begin r_val = s_q; r_sat = sat_s_q; end
      MODE_COS: begin r_val = c_q; r_sat = sat_c_q; end
      MODE_SEC, MODE_CSC, MODE_TAN, MODE_COT: begin
        if (q_dz) begin
          r_dz = 1'b1;
        end else if (q_neg) begin
          if (dvd_q > DW'(64'h8000_0000)) begin
            r_val = 32'h8000_0000;
            r_sat = 1'b1;
          end else begin
            r_val = VAL_W'(~dvd_q + 1'b1);
            r_sat = q_base;
          end
        end else begin
          if (dvd_q > DW'(64'h7FFF_FFFF)) begin
            r_val = 32'h7FFF_FFFF;
            r_sat = 1'b1;
          end else begin
            r_val = dvd_q[VAL_W-1:0];
            r_sat = q_base;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      value_q <= r_val;
      sat_q   <= r_sat;
      dz_q    <= r_dz;
    end
  end

  assign value_o          = value_q;
  assign saturated_o      = sat_q;
  assign divide_by_zero_o = dz_q;

  assign sts_o.t_below    = (t_q < tol);
  assign sts_o.mode_sine  = (mode_q == MODE_SIN);
  assign sts_o.mode_ratio = (mode_q == MODE_SEC) || (mode_q == MODE_CSC) ||
                            (mode_q == MODE_TAN) || (mode_q == MODE_COT);
  assign sts_o.quot_dz    = q_dz;

endmodule

@@ hw/rtl/tte_ctrl.sv @@
`timescale 1ns / 1ps
module tte_ctrl import tte_pkg::*; #(
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam int KW = $clog2(MAX_TERMS + 1);
  localparam int CW = $clog2(DW);
  localparam logic [CW-1:0] MUL_LAST = CW'(MUL_STEPS);
  localparam logic [CW-1:0] DIV_LAST = CW'(DW - 1);
  localparam logic [KW-1:0] K_LAST   = KW'(MAX_TERMS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_X2MUL  = 4'd1;
  localparam logic [3:0] S_SINIT  = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_TMUL   = 4'd4;
  localparam logic [3:0] S_TDIVST = 4'd5;
  localparam logic [3:0] S_TDIV   = 4'd6;
  localparam logic [3:0] S_TUPD   = 4'd7;
  localparam logic [3:0] S_SEREND = 4'd8;
  localparam logic [3:0] S_QDIVST = 4'd9;
  localparam logic [3:0] S_QDIV   = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [KW-1:0] k_q, k_d;
  logic          ser_q, ser_d;
  logic          ovld_q, ovld_d;
  logic          out_free;

  assign out_free    = !ovld_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovld_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    ser_d   = ser_q;
    cmd_o   = '0;
    cmd_o.ser_cos = ser_q;
    cmd_o.mul_idx = cnt_q[1:0];
    cmd_o.mul_clr = (cnt_q == '0);
    cmd_o.mul_acc = (cnt_q != '0);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          cnt_d   = '0;
          state_d = S_X2MUL;
        end
      end
      S_X2MUL, S_TMUL: begin
        cmd_o.mul_sel = (state_q == S_TMUL);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == MUL_LAST) begin
          state_d = (state_q == S_TMUL) ? S_TDIVST : S_SINIT;
        end
      end
      S_SINIT: begin
        cmd_o.x2_load  = 1'b1;
        cmd_o.ser_init = 1'b1;
        k_d     = '0;
        ser_d   = 1'b0;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if ((k_q == K_LAST) || sts_i.t_below) begin
          state_d = S_SEREND;
        end else begin
          cmd_o.ser_add = 1'b1;
          cmd_o.ser_sub = k_q[0];
          k_d     = k_q + 1'b1;
          cnt_d   = '0;
          state_d = S_TMUL;
        end
      end
      S_TDIVST: begin
        cmd_o.div_start = 1'b1;
        cnt_d   = '0;
        state_d = S_TDIV;
      end
      S_TDIV, S_QDIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = (state_q == S_TDIV) ? S_TUPD : S_OUT;
        end
      end
      S_TUPD: begin
        cmd_o.term_upd = 1'b1;
        state_d = S_CHECK;
      end
      S_SEREND: begin
        if (!ser_q) begin
          cmd_o.sin_store = 1'b1;
          if (sts_i.mode_sine) begin
            state_d = S_OUT;
          end else begin
            cmd_o.ser_init = 1'b1;
            cmd_o.init_cos = 1'b1;
            k_d     = '0;
            ser_d   = 1'b1;
            state_d = S_CHECK;
          end
        end else begin
          cmd_o.cos_store = 1'b1;
          state_d = sts_i.mode_ratio ? S_QDIVST : S_OUT;
        end
      end
      S_QDIVST: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_quot  = 1'b1;
        cnt_d   = '0;
        state_d = sts_i.quot_dz ? S_OUT : S_QDIV;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      ovld_d = 1'b1;
    end else if (out_ready_i) begin
      ovld_d = 1'b0;
    end else begin
      ovld_d = ovld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      ser_q   <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      ser_q   <= ser_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule

@@ hw/rtl/taylor_trig_evaluator.sv @@
`timescale 1ns / 1ps
// Each term costs a 32x32 partial-product multiply and a bit-serial divide; one
//   item is in flight, the next beat is taken once the result has moved into the
//   output register.
// Reset (rst_ni low, async): control idle, no result valid, tolerances 66 / 7.
module taylor_trig_evaluator import tte_pkg::*; #(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration writes
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [TOL_W-1:0]        cfg_wdata_i,
  // input beats
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [ANGLE_W-1:0]      angle_i,
  input  logic [MODE_W-1:0]       mode_i,
  // result beats
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [VAL_W-1:0] value_o,
  output logic                    saturated_o,
  output logic                    divide_by_zero_o
);

  // Tolerance registers: a term is summed while its magnitude is at least
  // this value (raw fixed point units).
  logic [TOL_W-1:0] sine_tol_q, cos_tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sine_tol_q <= SINE_TOL_RST;
      cos_tol_q  <= COS_TOL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SINE_TOL: sine_tol_q <= cfg_wdata_i;
        REG_COS_TOL:  cos_tol_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: x^2, then the sine series, then (except for sine) the cosine
  // series, then the optional quotient, then the output register.
  tte_ctrl #(
    .MAX_TERMS (MAX_TERMS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Shared multiplier, bit-serial divider, series accumulator, result register.
  tte_datapath #(
    .MAX_TERMS (MAX_TERMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .angle_i          (angle_i),
    .mode_i           (mode_i),
    .sine_tol_i       (sine_tol_q),
    .cos_tol_i        (cos_tol_q),
    .value_o          (value_o),
    .saturated_o      (saturated_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

endmodule

@@ sim/trig_result_checker.sv @@
`timescale 1ns / 1ps
module trig_result_checker import tte_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [TOL_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [ANGLE_W-1:0]      angle_i,
  input  logic [MODE_W-1:0]       mode_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic                    saturated_i,
  input  logic                    divide_by_zero_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      checked_o
);

  localparam int TERMS = 16;
  localparam int FRAC  = 16;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    sat;
    logic                    dz;
  } trig_result_t;

  trig_result_t      expected_q[$];
  logic [TOL_W-1:0]  sine_tol;
  logic [TOL_W-1:0]  cos_tol;

  // floor(a*b / 2^FRAC)
  function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
    longint unsigned m, ah, al, bh, bl;
    m  = (64'd1 << FRAC) - 1;
    ah = a >> FRAC;
    al = a & m;
    bh = b >> FRAC;
    bl = b & m;
    return ah * b + al * bh + ((al * bl) >> FRAC);
  endfunction

  function automatic longint taylor_sum(longint unsigned first, longint unsigned x2,
                                        longint unsigned power, longint unsigned tol);
    longint          sum;
    longint unsigned t, n;
    sum = 0;
    t   = first;
    n   = power;
    for (int k = 0; k < TERMS; k++) begin
      if (t < tol) break;
      if (k % 2 == 1) sum -= longint'(t);
      else            sum += longint'(t);
      t = fx_mul(t, x2) / ((n + 1) * (n + 2));
      n += 2;
    end
    return sum;
  endfunction

  function automatic longint clamp32(longint v, inout logic flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint fx_div(longint a, longint b, inout logic sat, inout logic dz);
    longint unsigned ua, ub, q;
    logic            neg;
    if (b == 0) begin
      dz  = 1'b1;
      sat = 1'b0;
      return 0;
    end
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? longint'(-a) : a;
    ub  = (b < 0) ? longint'(-b) : b;
    q   = (ua << FRAC) / ub;
    if (neg) begin
      if (q > (64'd1 << 31)) begin
        sat = 1'b1;
        return -64'sd2147483648;
      end
      return -longint'(q);
    end
    if (q > 64'd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    return longint'(q);
  endfunction

  function automatic trig_result_t eval_trig(logic [ANGLE_W-1:0] angle,
                                             logic [MODE_W-1:0] mode);
    trig_result_t    r;
    longint unsigned one, x, x2;
    longint          s, c, v;
    logic            sat, sat_s, dz;
    one = 64'd1 << FRAC;
    x   = (longint'(angle) << FRAC) >> ANGLE_FRAC;
    x2  = fx_mul(x, x);
    sat = 1'b0;
    dz  = 1'b0;
    s   = clamp32(taylor_sum(x, x2, 1, sine_tol), sat);
    if (mode == MODE_SIN) begin
      v = s;
    end else begin
      sat_s = sat;
      sat   = 1'b0;
      c     = clamp32(taylor_sum(one, x2, 0, cos_tol), sat);
      case (mode)
        MODE_COS: v = c;
        MODE_SEC: v = fx_div(one, c, sat, dz);
        MODE_CSC: begin
          sat = sat_s;
          v   = fx_div(one, s, sat, dz);
        end
        MODE_TAN: begin
          sat = sat | sat_s;
          v   = fx_div(s, c, sat, dz);
        end
        MODE_COT: begin
          sat = sat | sat_s;
          v   = fx_div(c, s, sat, dz);
        end
        default: begin
          v   = 0;
          sat = 1'b0;
          dz  = 1'b0;
        end
      endcase
    end
    r.value = v[VAL_W-1:0];
    r.sat   = sat;
    r.dz    = dz;
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    trig_result_t exp_r;
    if (!rst_ni) begin
      sine_tol     <= SINE_TOL_RST;
      cos_tol      <= COS_TOL_RST;
      fail_count_o <= 0;
      checked_o    <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_SINE_TOL) sine_tol <= cfg_wdata_i;
        else                           cos_tol  <= cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(eval_trig(angle_i, mode_i));
      if (out_valid_i && out_ready_i) begin
        checked_o <= checked_o + 1;
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("[%0t] unexpected result beat: value %0d", $time, value_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.value !== value_i || exp_r.sat !== saturated_i ||
              exp_r.dz !== divide_by_zero_i) begin
            if (fail_count_o < 10)
              $display("[%0t] result: exp value %0d sat %0b dz %0b, got %0d %0b %0b",
                       $time, exp_r.value, exp_r.sat, exp_r.dz,
                       value_i, saturated_i, divide_by_zero_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import tte_pkg::*;

  localparam longint CYCLE_LIMIT = 40_000_000; // well above the worst case for all items, several times over
  localparam int     RAND_ITEMS  = 1900;
  localparam int     PHASES      = 6;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic                    cfg_idx_i;
  logic [TOL_W-1:0]        cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [ANGLE_W-1:0]      angle_i;
  logic [MODE_W-1:0]       mode_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [VAL_W-1:0] value_o;
  logic                    saturated_o;
  logic                    divide_by_zero_o;

  int     fail_count;
  int     pending;
  int     checked;
  int     sent;
  longint cycles;
  int     stall_left;
  logic   no_stall;     // receiver always ready during this stretch
  logic   no_gap;       // sender never pauses during this stretch

  taylor_trig_evaluator dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .angle_i, .mode_i,
    .out_valid_o, .out_ready_i, .value_o, .saturated_o, .divide_by_zero_o
  );

  trig_result_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .angle_i, .mode_i,
    .out_valid_i(out_valid_o), .out_ready_i, .value_i(value_o),
    .saturated_i(saturated_o), .divide_by_zero_i(divide_by_zero_o),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("taylor_trig_evaluator: mismatch");
      $finish;
    end
  end

  // receiver: mostly short random stalls, occasionally a long one
  always @(posedge clk_i) begin
    if (no_stall) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(99) < 3) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(300, 20);
    end else begin
      out_ready_i <= ($urandom_range(3) != 0);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_gap || r < 65) return 0;
    if (r < 95) return $urandom_range(4, 1);
    return $urandom_range(400, 30);
  endfunction

  // one input beat; valid stays up across back-to-back beats
  task automatic send_item(logic [ANGLE_W-1:0] angle, logic [MODE_W-1:0] mode);
    int gap;
    in_valid_i <= 1'b1;
    angle_i    <= angle;
    mode_i     <= mode;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_tolerances(logic [TOL_W-1:0] sine_tol, logic [TOL_W-1:0] cos_tol);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_SINE_TOL;
    cfg_wdata_i <= sine_tol;
    @(posedge clk_i);
    cfg_idx_i   <= REG_COS_TOL;
    cfg_wdata_i <= cos_tol;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // drop valid, let the block drain completely
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // angles near the landmarks (0, 1.0, pi/2, pi), anywhere in 0..2pi or anywhere in the field
  function automatic logic [ANGLE_W-1:0] rand_angle();
    int r;
    r = $urandom_range(9);
    case (r)
      0: return ANGLE_W'($urandom_range(102944 + 64, 102944 - 64));
      1: return ANGLE_W'($urandom_range(205887 + 64, 205887 - 64));
      2: return ANGLE_W'($urandom_range(66000, 65000));
      3: return ANGLE_W'($urandom_range(524287));
      4: return ANGLE_W'($urandom_range(64));
      default: return ANGLE_W'($urandom_range(411775));
    endcase
  endfunction

  initial begin
    logic [TOL_W-1:0] stol;
    logic [TOL_W-1:0] ctol;
    int               per_phase;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_SINE_TOL;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    angle_i     <= '0;
    mode_i      <= MODE_SIN;
    out_ready_i <= 1'b0;
    stall_left  <= 0;
    no_stall    <= 1'b0;
    no_gap      <= 1'b0;
    cycles      <= 0;
    sent         = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset tolerances: zero angle hits the zero divisor in csc / cot,
    // x = 1.0 is the old early-stop trap, top angles stress the saturation path
    for (int m = 0; m < 8; m++) send_item('0, MODE_W'(m));
    for (int m = 0; m < 6; m++) send_item(ANGLE_W'(65536), MODE_W'(m));
    send_item(ANGLE_W'(411775), MODE_SIN);
    send_item(ANGLE_W'(411775), MODE_COS);
    send_item(ANGLE_W'(411775), MODE_CSC);
    send_item('1, MODE_TAN);
    send_item('1, MODE_COT);
    send_item('1, MODE_SEC);
    send_item(ANGLE_W'(102944), MODE_TAN);
    send_item(ANGLE_W'(205887), MODE_COT);

    // sender holds off until the block is empty
    drain();

    // tolerance settings per phase: reset, one, maximum, zero, random mixes
    per_phase = RAND_ITEMS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin stol = SINE_TOL_RST; ctol = COS_TOL_RST; end
        1: begin stol = 16'd1;        ctol = 16'd1;       end
        2: begin stol = 16'hFFFF;     ctol = 16'hFFFF;    end
        3: begin stol = '0;           ctol = '0;          end
        default: begin
          stol = TOL_W'($urandom_range(65535));
          ctol = TOL_W'($urandom_range(2000));
        end
      endcase
      write_tolerances(stol, ctol);
      for (int i = 0; i < per_phase; i++) begin
        // every 100 items, each side may get a stretch with no idling
        if (i % 100 == 0) begin
          no_stall <= ($urandom_range(3) == 0);
          no_gap   <= ($urandom_range(3) == 0);
        end
        send_item(rand_angle(), MODE_W'($urandom_range(7)));
      end
      drain();
      no_stall <= 1'b0;
      no_gap   <= 1'b0;
    end

    drain();
    repeat (3000) @(posedge clk_i);

    $display("sent %0d angle/mode beats over %0d tolerance settings, checked %0d results",
             sent, PHASES + 1, checked);
    $display("modes 0..7, zero divisors, saturation and out-of-range angles included");
    if (fail_count == 0 && pending == 0) begin
      $display("taylor_trig_evaluator: match");
    end else begin
      $display("taylor_trig_evaluator: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/tte_pkg.sv
hw/rtl/tte_datapath.sv
hw/rtl/tte_ctrl.sv
hw/rtl/taylor_trig_evaluator.sv
sim/trig_result_checker.sv
sim/testbench.sv
